[rtl/lpcwt_pkg.sv]
package lpcwt_pkg;

  localparam int COORD_W = 40;
  localparam int QUAT_W = 16;
  localparam int QFRAC = QUAT_W - 2;
  localparam int MFRAC = 2 * QFRAC;
  localparam int MAT_W = 2 * QUAT_W + 3;
  localparam int LIMB_W = COORD_W / 2;
  localparam int PROD_W = MAT_W + LIMB_W + 1;
  localparam int ACC_W = MAT_W + COORD_W + 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_EXT_QX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_QY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_QZ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_QW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_TX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_TY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_TZ = 3'd6;

  localparam logic REQ_POSE = 1'b0;
  localparam logic REQ_POINT = 1'b1;

  localparam logic signed [COORD_W-1:0] X_LIM = 40'sd1310720;
  localparam logic signed [COORD_W-1:0] Y_LIM = 40'sd327680;
  localparam logic signed [COORD_W-1:0] Z_LIM = -40'sd98304;
  localparam logic [7:0] INT_MIN = 8'd50;

  typedef struct packed {
    logic req_type;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
    logic signed [QUAT_W-1:0] in_qx;
    logic signed [QUAT_W-1:0] in_qy;
    logic signed [QUAT_W-1:0] in_qz;
    logic signed [QUAT_W-1:0] in_qw;
    logic [7:0] in_intensity;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] world_x;
    logic signed [COORD_W-1:0] world_y;
    logic signed [COORD_W-1:0] world_z;
    logic [7:0] out_intensity;
    logic clipped;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QMUL,
    ST_MAT,
    ST_ROW,
    ST_DONE,
    ST_OUT
  } state_t;

endpackage

[rtl/lidar_point_crop_and_world_transform_core.sv]
// A pose item or a dropped point is taken without leaving ST_IDLE; a kept point
// is rotated by the extrinsic, then the pose: 9 quaternion products, the matrix,
// the row terms (each in two 20-bit halves, with a writeback per row) and a done
// step, then the output step, all through one shared 35x21 multiplier.
// One item at a time; a waiting result stalls only the next kept point.
// Synchronous active-high reset restores identity extrinsic.
module lidar_point_crop_and_world_transform_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  lpcwt_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output lpcwt_pkg::out_item_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [lpcwt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpcwt_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = lpcwt_pkg::COORD_W;
  localparam int QW = lpcwt_pkg::QUAT_W;
  localparam int MW = lpcwt_pkg::MAT_W;
  localparam int PW = lpcwt_pkg::PROD_W;
  localparam int AW = lpcwt_pkg::ACC_W;
  localparam int LW = lpcwt_pkg::LIMB_W;

  lpcwt_pkg::state_t state, state_next;

  logic signed [QW-1:0] ext_q [4];
  logic signed [CW-1:0] ext_t [3];
  logic origin_valid;
  logic signed [CW-1:0] origin_pos [3];
  logic signed [CW-1:0] pose_t [3];
  logic signed [QW-1:0] pose_q [4];

  logic signed [CW-1:0] pt [3];
  logic [7:0] inten;
  logic stage;
  logic clip;
  logic signed [2*QW-1:0] qp [9];
  logic signed [MW-1:0] mat [9];
  logic [3:0] cnt;
  logic [1:0] row, col;
  logic half;
  logic signed [AW-1:0] acc;
  logic signed [CW-1:0] res [3];
  lpcwt_pkg::out_item_t out_reg;

  // shared multiplier operands
  logic signed [MW-1:0] mul_a;
  logic signed [LW:0] mul_b;
  logic signed [PW-1:0] prod;

  logic signed [QW-1:0] qa, qb;
  logic signed [QW-1:0] qsel [4];
  logic [3:0] mi;

  always_comb begin
    for (int i = 0; i < 4; i++) qsel[i] = stage ? pose_q[i] : ext_q[i];
    // products: xx yy zz xy xz yz xw yw zw (index 0..8)
    unique case (cnt)
      4'd0: begin qa = qsel[0]; qb = qsel[0]; end
      4'd1: begin qa = qsel[1]; qb = qsel[1]; end
      4'd2: begin qa = qsel[2]; qb = qsel[2]; end
      4'd3: begin qa = qsel[0]; qb = qsel[1]; end
      4'd4: begin qa = qsel[0]; qb = qsel[2]; end
      4'd5: begin qa = qsel[1]; qb = qsel[2]; end
      4'd6: begin qa = qsel[0]; qb = qsel[3]; end
      4'd7: begin qa = qsel[1]; qb = qsel[3]; end
      4'd8: begin qa = qsel[2]; qb = qsel[3]; end
      default: begin qa = '0; qb = '0; end
    endcase
    mi = 4'({28'd0, row} * 32'd3 + {30'd0, col});
    if (state == lpcwt_pkg::ST_QMUL) begin
      mul_a = MW'(qa);
      mul_b = (LW+1)'(qb);
    end else if (col != 2'd3) begin
      mul_a = mat[mi];
      mul_b = half ? (LW+1)'($signed(pt[col][CW-1:LW])) : {1'b0, pt[col][LW-1:0]};
    end else begin
      mul_a = '0;
      mul_b = '0;
    end
    prod = PW'(mul_a) * PW'(mul_b);
  end

  logic signed [MW-1:0] one_m;
  assign one_m = MW'(1) <<< lpcwt_pkg::MFRAC;

  // rounding and saturation of the finished row
  logic signed [AW-1:0] rnd;
  logic signed [AW-1:0] sh;
  logic signed [CW-1:0] sat_v;
  logic sat_hit;
  logic signed [AW-1:0] cmax, cmin;
  assign cmax = AW'({1'b0, {(CW-1){1'b1}}});
  assign cmin = -cmax - AW'(1);
  always_comb begin
    rnd = acc + (AW'(1) <<< (lpcwt_pkg::MFRAC - 1));
    sh = rnd >>> lpcwt_pkg::MFRAC;
    sat_hit = 1'b1;
    if (sh > cmax) sat_v = cmax[CW-1:0];
    else if (sh < cmin) sat_v = cmin[CW-1:0];
    else begin
      sat_v = sh[CW-1:0];
      sat_hit = 1'b0;
    end
  end

  logic signed [CW:0] pdiff [3];
  logic signed [CW-1:0] psat [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pdiff[i] = (CW+1)'(in_data.in_x) - (CW+1)'(origin_pos[i]);
      unique case (i)
        0: pdiff[i] = (CW+1)'(in_data.in_x) - (CW+1)'(origin_pos[0]);
        1: pdiff[i] = (CW+1)'(in_data.in_y) - (CW+1)'(origin_pos[1]);
        default: pdiff[i] = (CW+1)'(in_data.in_z) - (CW+1)'(origin_pos[2]);
      endcase
      if (pdiff[i][CW] != pdiff[i][CW-1])
        psat[i] = pdiff[i][CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      else psat[i] = pdiff[i][CW-1:0];
    end
  end

  logic keep;
  assign keep = in_data.in_x < lpcwt_pkg::X_LIM && in_data.in_x > -lpcwt_pkg::X_LIM &&
                in_data.in_y < lpcwt_pkg::Y_LIM && in_data.in_y > -lpcwt_pkg::Y_LIM &&
                in_data.in_z < lpcwt_pkg::Z_LIM && in_data.in_intensity > lpcwt_pkg::INT_MIN;

  logic in_fire;
  logic out_free;
  assign in_ready = (state == lpcwt_pkg::ST_IDLE);
  assign in_fire = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign out_data = out_reg;

  always_comb begin
    state_next = state;
    unique case (state)
      lpcwt_pkg::ST_IDLE:
        if (in_fire && in_data.req_type == lpcwt_pkg::REQ_POINT && keep)
          state_next = lpcwt_pkg::ST_QMUL;
      lpcwt_pkg::ST_QMUL: if (cnt == 4'd8) state_next = lpcwt_pkg::ST_MAT;
      lpcwt_pkg::ST_MAT: state_next = lpcwt_pkg::ST_ROW;
      lpcwt_pkg::ST_ROW:
        if (col == 2'd3) begin
          if (row == 2'd2) state_next = lpcwt_pkg::ST_DONE;
        end
      lpcwt_pkg::ST_DONE:
        state_next = stage ? lpcwt_pkg::ST_OUT : lpcwt_pkg::ST_QMUL;
      lpcwt_pkg::ST_OUT: if (out_free) state_next = lpcwt_pkg::ST_IDLE;
      default: state_next = lpcwt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lpcwt_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_q[0] <= '0; ext_q[1] <= '0; ext_q[2] <= '0;
      ext_q[3] <= QW'(1) <<< lpcwt_pkg::QFRAC;
      for (int i = 0; i < 3; i++) begin
        ext_t[i] <= '0;
        origin_pos[i] <= '0;
        pose_t[i] <= '0;
      end
      for (int i = 0; i < 4; i++) pose_q[i] <= '0;
      origin_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          lpcwt_pkg::REG_EXT_QX: ext_q[0] <= cfg_data[QW-1:0];
          lpcwt_pkg::REG_EXT_QY: ext_q[1] <= cfg_data[QW-1:0];
          lpcwt_pkg::REG_EXT_QZ: ext_q[2] <= cfg_data[QW-1:0];
          lpcwt_pkg::REG_EXT_QW: ext_q[3] <= cfg_data[QW-1:0];
          lpcwt_pkg::REG_EXT_TX: ext_t[0] <= cfg_data[CW-1:0];
          lpcwt_pkg::REG_EXT_TY: ext_t[1] <= cfg_data[CW-1:0];
          lpcwt_pkg::REG_EXT_TZ: ext_t[2] <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
      if (in_fire && in_data.req_type == lpcwt_pkg::REQ_POSE) begin
        if (!origin_valid) begin
          origin_pos[0] <= in_data.in_x;
          origin_pos[1] <= in_data.in_y;
          origin_pos[2] <= in_data.in_z;
          origin_valid <= 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) pose_t[i] <= psat[i];
          pose_q[0] <= in_data.in_qx;
          pose_q[1] <= in_data.in_qy;
          pose_q[2] <= in_data.in_qz;
          pose_q[3] <= in_data.in_qw;
        end
      end
      if (state == lpcwt_pkg::ST_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      lpcwt_pkg::ST_IDLE: begin
        pt[0] <= in_data.in_x;
        pt[1] <= in_data.in_y;
        pt[2] <= in_data.in_z;
        inten <= in_data.in_intensity;
        stage <= 1'b0;
        clip <= 1'b0;
        cnt <= '0;
      end
      lpcwt_pkg::ST_QMUL: begin
        qp[cnt] <= prod[2*QW-1:0];
        cnt <= cnt + 4'd1;
      end
      lpcwt_pkg::ST_MAT: begin
        mat[0] <= one_m - ((MW'(qp[1]) + MW'(qp[2])) <<< 1);
        mat[1] <= (MW'(qp[3]) - MW'(qp[8])) <<< 1;
        mat[2] <= (MW'(qp[4]) + MW'(qp[7])) <<< 1;
        mat[3] <= (MW'(qp[3]) + MW'(qp[8])) <<< 1;
        mat[4] <= one_m - ((MW'(qp[0]) + MW'(qp[2])) <<< 1);
        mat[5] <= (MW'(qp[5]) - MW'(qp[6])) <<< 1;
        mat[6] <= (MW'(qp[4]) - MW'(qp[7])) <<< 1;
        mat[7] <= (MW'(qp[5]) + MW'(qp[6])) <<< 1;
        mat[8] <= one_m - ((MW'(qp[0]) + MW'(qp[1])) <<< 1);
        row <= '0;
        col <= '0;
        half <= 1'b0;
        acc <= AW'(stage ? pose_t[0] : ext_t[0]) <<< lpcwt_pkg::MFRAC;
      end
      lpcwt_pkg::ST_ROW: begin
        if (col == 2'd3) begin
          res[row] <= sat_v;
          clip <= clip | sat_hit;
          col <= '0;
          row <= row + 2'd1;
          if (row != 2'd2)
            acc <= AW'(stage ? pose_t[row + 2'd1] : ext_t[row + 2'd1]) <<<
                   lpcwt_pkg::MFRAC;
        end else begin
          acc <= acc + (half ? (AW'(prod) <<< LW) : AW'(prod));
          half <= ~half;
          if (half) col <= col + 2'd1;
        end
      end
      lpcwt_pkg::ST_DONE: begin
        for (int i = 0; i < 3; i++) pt[i] <= res[i];
        stage <= 1'b1;
        cnt <= '0;
      end
      lpcwt_pkg::ST_OUT: begin
        if (out_free) begin
          out_reg.world_x <= pt[0];
          out_reg.world_y <= pt[1];
          out_reg.world_z <= pt[2];
          out_reg.out_intensity <= inten;
          out_reg.clipped <= clip;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while waiting");
  a_out_after_calc: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == lpcwt_pkg::ST_OUT)
    else $error("result without computation");
  a_origin_sticky: assert property (@(posedge clk) disable iff (rst)
    origin_valid |=> origin_valid)
    else $error("origin flag dropped");
`endif

endmodule
